/* src/selective_repeat_receiver_macros.svh */
// ---------------------------------------------------------------------------
// selective_repeat_receiver_macros.svh
// Assertion helpers shared by the selective-repeat receiver RTL.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("selective_repeat_receiver: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("selective_repeat_receiver: next-cycle check failed");

`endif

/* src/srr_pkg.sv */
// ---------------------------------------------------------------------------
// srr_pkg
// Beat types, controller/datapath command and status, fixed constants.
// ---------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

    // Fixed field widths
    localparam int FRAME_W = 8;
    localparam int FIRST_W = 7;
    localparam int COUNT_W = 8;

    // Bitmap bits examined per scan cycle
    localparam int WIN   = 8;
    localparam int WIN_W = 4;

    // Frame limit after reset
    localparam logic [FRAME_W-1:0] LIMIT_RESET = 8'd100;

    // Input beat
    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic               end_marker;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [FRAME_W-1:0] ack_frame;
        logic               duplicate;
        logic               in_order;
        logic [FIRST_W-1:0] deliver_first;
        logic [COUNT_W-1:0] deliver_count;
    } t_out_beat;

    // Controller to datapath
    typedef struct packed {
        logic take_item;   // input beat accepted this cycle
        logic scan_step;   // advance delivery pointer over one window
        logic load_out;    // move finished result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_live;   // input beat will yield a result
        logic scan_done;   // run ends inside the current window
        logic out_free;    // output register can take a result this cycle
    } t_stat;

endpackage

`default_nettype wire

/* src/srr_ctrl.sv */
// ---------------------------------------------------------------------------
// srr_ctrl
// Sequencer: accept, scan the bitmap window by window, hand off the result.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire srr_pkg::t_stat i_stat,
    output srr_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);
    import srr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.take_item = in_acc;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_stat.item_live) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    if (i_stat.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* src/srr_dp.sv */
// ---------------------------------------------------------------------------
// srr_dp
// Received bitmap, delivery pointer, frame limit and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_dp #(
    parameter int SEQ_SPACE = 128
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire srr_pkg::t_in_beat     i_in_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [7:0]            i_cfg_wdata,
    input  wire logic                  i_out_stall,
    input  wire srr_pkg::t_cmd         i_cmd,
    output srr_pkg::t_stat             o_stat,
    output logic                       o_out_valid,
    output srr_pkg::t_out_beat         o_out_data
);
    import srr_pkg::*;

    // Frames are 8 bits and the limit is at most 255, so no frame above 254
    // is ever marked: the bitmap stops there.
    localparam int MAP_DEPTH = (SEQ_SPACE < 255) ? SEQ_SPACE : 255;

    logic [MAP_DEPTH-1:0] r_map;
    logic [MAP_DEPTH-1:0] n_map;
    logic [FRAME_W-1:0]   r_ptr;
    logic [FRAME_W-1:0]   r_limit;
    logic                 r_fin;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_dup;
    logic                 r_inord;
    logic [FIRST_W-1:0]   r_first;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_out_valid;
    t_out_beat            r_out;

    logic [FRAME_W-1:0]     eff_lim;
    logic                   hit;
    logic [MAP_DEPTH+WIN-1:0] map_ext;
    logic [WIN-1:0]         win;
    logic [WIN_W-1:0]       run_len;
    logic                   run;
    logic [COUNT_W-1:0]     fin_count;
    logic                   item_live;
    logic                   scan_done;
    logic                   out_free;

    // Effective limit saturates at the bitmap size
    assign eff_lim = (32'(r_limit) > MAP_DEPTH) ? FRAME_W'(MAP_DEPTH) : r_limit;

    // Lookup and mark of the arriving frame
    always_comb begin
        hit   = 1'b0;
        n_map = r_map;
        for (int k = 0; k < MAP_DEPTH; k++) begin
            if (i_in_data.frame_number == FRAME_W'(k)) begin
                hit      = hit | r_map[k];
                n_map[k] = 1'b1;
            end
        end
    end

    assign item_live = !r_fin && !i_in_data.end_marker &&
                       (i_in_data.frame_number < eff_lim);

    // Window of the bitmap from the pointer, masked at the limit
    assign map_ext = {{WIN{1'b0}}, r_map};
    always_comb begin
        win = WIN'(map_ext >> r_ptr);
        for (int k = 0; k < WIN; k++) begin
            if (({1'b0, r_ptr} + (FRAME_W+1)'(k)) >= {1'b0, eff_lim}) begin
                win[k] = 1'b0;
            end
        end
    end

    // Length of the run of received frames at the start of the window
    always_comb begin
        run     = 1'b1;
        run_len = '0;
        for (int k = 0; k < WIN; k++) begin
            run     = run & win[k];
            run_len = run_len + WIN_W'(run);
        end
    end

    assign scan_done = (run_len != WIN_W'(WIN));
    assign out_free  = !r_out_valid || !i_out_stall;

    // Status back to the sequencer
    assign o_stat = '{item_live: item_live, scan_done: scan_done, out_free: out_free};

    assign fin_count = r_count + (i_cmd.scan_step ? COUNT_W'(run_len) : '0);

    // Control state: bitmap, pointer, limit, end flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_ptr       <= '0;
            r_limit     <= LIMIT_RESET;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.take_item) begin
                if (item_live) begin
                    r_map <= n_map;
                end
                if (!r_fin && i_in_data.end_marker) begin
                    r_fin <= 1'b1;
                end
            end
            if (i_cmd.scan_step) begin
                r_ptr <= r_ptr + FRAME_W'(run_len);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_frame <= i_in_data.frame_number;
            r_dup   <= hit;
            r_inord <= !hit && (i_in_data.frame_number == r_ptr);
            r_first <= r_ptr[FIRST_W-1:0];
            r_count <= '0;
        end else if (i_cmd.scan_step) begin
            r_count <= fin_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.ack_frame     <= r_frame;
            r_out.duplicate     <= r_dup;
            r_out.in_order      <= r_inord;
            r_out.deliver_first <= (fin_count == '0) ? '0 : r_first;
            r_out.deliver_count <= fin_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* src/selective_repeat_receiver.sv */
// ---------------------------------------------------------------------------
// selective_repeat_receiver
// Receiver side of selective-repeat ARQ: marks frames, acknowledges them and
// reports the run of frames now deliverable in order.
// ---------------------------------------------------------------------------
//  Channel  Handshake                Payload
//  in       i_in_valid / o_in_stall  i_in_data  (frame_number, end_marker)
//  out      o_out_valid / i_out_stall o_out_data (ack, flags, run first/count)
//  cfg      i_cfg_we                 i_cfg_wdata (frame_limit)
//
//  For a frame that yields a result, the accept edge marks the bitmap, then
//  the scan over the bitmap from the delivery pointer covers 8 bits a cycle
//  until the run ends. Dropped frames, end markers and beats after the end
//  start no scan and leave the input ready again.
//  Synchronous active-low reset clears the bitmap at once; limit resets to 100.
//  A stalled output holds its beat; the next input beat is still accepted, but
//  its result then waits after the scan, holding the input off until it moves.
// ---------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receiver #(
    parameter int SEQ_SPACE = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire srr_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output srr_pkg::t_out_beat      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_wdata
);
    import srr_pkg::*;

    `include "selective_repeat_receiver_macros.svh"

    t_cmd  cmd;
    t_stat st;
    logic  in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // Sequencer
    srr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (st),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Bitmap, pointer and output register
    srr_dp #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (st),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A pending result is never overwritten
    `SRR_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, st.out_free)
    // A beat with no result leaves the block ready again
    `SRR_ASSERT_NEXT(a_drop_ready, i_clk, i_rst_n, in_acc && !st.item_live, !o_in_stall)
    // A beat with a result starts the scan
    `SRR_ASSERT_NEXT(a_live_busy, i_clk, i_rst_n, in_acc && st.item_live, o_in_stall)

endmodule

`default_nettype wire
